// ===== rtl/vfcao_pkg.sv =====
// ----------------------------------------------------------------------------
// vfcao_pkg
// Shared types, codes and tables of the voxel face cull / AO block.
// ----------------------------------------------------------------------------
package vfcao_pkg;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_MESH    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam int CNT_W  = 17;
    localparam int BASE_W = 19;

    // Neighborhood cube index: 9*(dx+1) + 3*(dz+1) + (dy+1).
    localparam logic [4:0] CUBE_CENTER = 5'd13;

    localparam logic [4:0] NB_IDX [6] = '{5'd10, 5'd16, 5'd4, 5'd22, 5'd12, 5'd14};

    // Per direction, per corner (bl, br, tl, tr): side1, side2, corner.
    localparam logic [4:0] AO_IDX [6][4][3] = '{
        '{'{5'd1,  5'd13, 5'd4 }, '{5'd13, 5'd19, 5'd22},
          '{5'd2,  5'd14, 5'd5 }, '{5'd14, 5'd20, 5'd23}},
        '{'{5'd13, 5'd25, 5'd22}, '{5'd13, 5'd7,  5'd4 },
          '{5'd14, 5'd26, 5'd23}, '{5'd14, 5'd8,  5'd5 }},
        '{'{5'd13, 5'd7,  5'd16}, '{5'd13, 5'd1,  5'd10},
          '{5'd14, 5'd8,  5'd17}, '{5'd14, 5'd2,  5'd11}},
        '{'{5'd13, 5'd19, 5'd10}, '{5'd13, 5'd25, 5'd16},
          '{5'd14, 5'd20, 5'd11}, '{5'd14, 5'd26, 5'd17}},
        '{'{5'd3,  5'd15, 5'd6 }, '{5'd21, 5'd15, 5'd24},
          '{5'd3,  5'd9,  5'd0 }, '{5'd21, 5'd9,  5'd18}},
        '{'{5'd5,  5'd11, 5'd2 }, '{5'd23, 5'd11, 5'd20},
          '{5'd5,  5'd17, 5'd8 }, '{5'd23, 5'd17, 5'd26}}
    };

    typedef struct packed {
        logic clr_step;
        logic take;
        logic rd_step;
        logic build;
        logic face_step;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_mesh;
        logic rd_done;
        logic emit;
        logic out_pop;
        logic out_last;
    } t_sts;

    // Returns {bl, br, tl, tr} levels, two bits each.
    function automatic logic [7:0] ao_levels(input logic [26:0] cube, input logic [2:0] dir);
        logic [7:0] res;
        logic       s1;
        logic       s2;
        logic       c;
        res = 8'd0;
        for (int k = 0; k < 4; k++) begin
            s1 = 1'b0;
            s2 = 1'b0;
            c  = 1'b0;
            for (int d = 0; d < 6; d++) begin
                if (dir == 3'(d)) begin
                    s1 = cube[AO_IDX[d][k][0]];
                    s2 = cube[AO_IDX[d][k][1]];
                    c  = cube[AO_IDX[d][k][2]];
                end
            end
            res[7-2*k -: 2] = (s1 && s2) ? 2'd0 :
                              2'(2'd3 - ({1'b0, s1} + {1'b0, s2} + {1'b0, c}));
        end
        return res;
    endfunction

endpackage

// ===== rtl/vfcao_ctrl.sv =====
// ----------------------------------------------------------------------------
// vfcao_ctrl
// Sequencer: clearing pass, item intake, column reads, face walk, output wait.
// ----------------------------------------------------------------------------
module vfcao_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  vfcao_pkg::t_sts i_sts,
    output vfcao_pkg::t_cmd o_cmd
);
    import vfcao_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_BUILD = 7'b0010000,
        S_FACE  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_sts.is_mesh) n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd_step = 1'b1;
                if (i_sts.rd_done) n_state = S_WAIT;
            end
            S_WAIT:  n_state = S_BUILD;
            S_BUILD: begin
                o_cmd.build = 1'b1;
                n_state     = S_FACE;
            end
            S_FACE: begin
                o_cmd.face_step = 1'b1;
                if (i_sts.emit) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_pop) n_state = i_sts.out_last ? S_IDLE : S_FACE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/vfcao_dp.sv =====
// ----------------------------------------------------------------------------
// vfcao_dp
// Occupancy memory, neighbor column buffer, AO evaluation and output register.
// ----------------------------------------------------------------------------
module vfcao_dp #(
    parameter int CHUNK_SIZE = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vfcao_pkg::t_cmd              i_cmd,
    output vfcao_pkg::t_sts              o_sts,
    input  logic [1:0]                   i_mode,
    input  logic [4:0]                   i_cell_x,
    input  logic [4:0]                   i_cell_z,
    input  logic [4:0]                   i_cell_y,
    input  logic [31:0]                  i_column_bits,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_face_valid,
    output logic [2:0]                   o_face_dir,
    output logic [4:0]                   o_face_x,
    output logic [4:0]                   o_face_y,
    output logic [4:0]                   o_face_z,
    output logic [1:0]                   o_ao_bottom_left,
    output logic [1:0]                   o_ao_bottom_right,
    output logic [1:0]                   o_ao_top_left,
    output logic [1:0]                   o_ao_top_right,
    output logic [vfcao_pkg::BASE_W-1:0] o_base_vertex,
    output logic                         o_last_face
);
    import vfcao_pkg::*;

    localparam int DEPTH = CHUNK_SIZE * CHUNK_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int YW    = $clog2(CHUNK_SIZE);
    localparam logic [6:0]  CS7 = 7'(CHUNK_SIZE);
    localparam logic [12:0] CS13 = 13'(CHUNK_SIZE);

    logic [CHUNK_SIZE-1:0] r_mem [DEPTH];
    logic [CHUNK_SIZE-1:0] r_rdata;
    logic [CHUNK_SIZE-1:0] r_col [9];
    logic [AW-1:0]         r_clr;
    logic [4:0]            r_x;
    logic [4:0]            r_y;
    logic [4:0]            r_z;
    logic [1:0]            r_rx;
    logic [1:0]            r_rz;
    logic                  r_cap;
    logic [3:0]            r_cap_idx;
    logic                  r_cap_oob;
    logic [26:0]           r_cube;
    logic [5:0]            r_mask;
    logic [2:0]            r_dir;
    logic [CNT_W-1:0]      r_count;
    logic                  r_ovalid;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [CHUNK_SIZE-1:0] wdata;
    logic [AW-1:0]         raddr;
    logic [6:0]            cx;
    logic [6:0]            cz;
    logic                  rd_oob;
    logic [26:0]           cube;
    logic [5:0]            mask;
    logic [6:0]            yv;
    logic [7:0]            ao;
    logic                  later;
    logic                  emit;
    logic                  pop;

    always_comb begin
        we    = 1'b0;
        waddr = r_clr;
        wdata = '0;
        if (i_cmd.clr_step) begin
            we = 1'b1;
        end else if (i_cmd.take && i_mode == MODE_LOAD &&
                     {2'b00, i_cell_x} < CS7 && {2'b00, i_cell_z} < CS7) begin
            we    = 1'b1;
            waddr = AW'(13'(i_cell_x) * CS13 + 13'(i_cell_z));
            wdata = CHUNK_SIZE'(i_column_bits);
        end
    end

    always_comb begin
        cx     = {2'b00, r_x} + {5'b0, r_rx} - 7'd1;
        cz     = {2'b00, r_z} + {5'b0, r_rz} - 7'd1;
        rd_oob = (cx >= CS7) || (cz >= CS7);
        raddr  = rd_oob ? '0 : AW'(13'(cx) * CS13 + 13'(cz));
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    always_comb begin
        cube = '0;
        for (int ox = 0; ox < 3; ox++) begin
            for (int oz = 0; oz < 3; oz++) begin
                for (int oy = 0; oy < 3; oy++) begin
                    yv = {2'b00, r_y} + 7'(oy) - 7'd1;
                    cube[ox*9 + oz*3 + oy] = (yv < CS7) ? r_col[ox*3 + oz][yv[YW-1:0]] : 1'b0;
                end
            end
        end
        for (int d = 0; d < 6; d++) begin
            mask[d] = cube[CUBE_CENTER] & ~cube[NB_IDX[d]];
        end
    end

    assign ao    = ao_levels(r_cube, r_dir);
    assign later = |(r_mask & (6'b111110 << r_dir));
    assign emit  = (r_mask == 6'd0) || r_mask[r_dir];
    assign pop   = r_ovalid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_rx     <= '0;
            r_rz     <= '0;
            r_cap    <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_dir    <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + AW'(1);
            r_cap <= i_cmd.rd_step;
            if (i_cmd.take) begin
                r_rx <= '0;
                r_rz <= '0;
                if (i_mode == MODE_RESTART) r_count <= '0;
            end
            if (i_cmd.rd_step) begin
                if (r_rz == 2'd2) begin
                    r_rz <= '0;
                    r_rx <= r_rx + 2'd1;
                end else begin
                    r_rz <= r_rz + 2'd1;
                end
            end
            if (i_cmd.build) r_dir <= '0;
            if (i_cmd.face_step) begin
                r_dir <= r_dir + 3'd1;
                if (emit) r_ovalid <= 1'b1;
                if (r_mask != 6'd0 && r_mask[r_dir]) r_count <= r_count + CNT_W'(1);
            end
            if (pop) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_x <= i_cell_x;
            r_y <= i_cell_y;
            r_z <= i_cell_z;
        end
        if (i_cmd.rd_step) begin
            r_cap_idx <= 4'({2'b00, r_rx} * 4'd3 + {2'b00, r_rz});
            r_cap_oob <= rd_oob;
        end
        if (r_cap) r_col[r_cap_idx] <= r_cap_oob ? '0 : r_rdata;
        if (i_cmd.build) begin
            r_cube <= cube;
            r_mask <= mask;
        end
        if (i_cmd.face_step && emit) begin
            if (r_mask == 6'd0) begin
                o_face_valid      <= 1'b0;
                o_face_dir        <= '0;
                o_face_x          <= '0;
                o_face_y          <= '0;
                o_face_z          <= '0;
                o_ao_bottom_left  <= '0;
                o_ao_bottom_right <= '0;
                o_ao_top_left     <= '0;
                o_ao_top_right    <= '0;
                o_base_vertex     <= '0;
                o_last_face       <= 1'b1;
            end else begin
                o_face_valid      <= 1'b1;
                o_face_dir        <= r_dir;
                o_face_x          <= r_x;
                o_face_y          <= r_y;
                o_face_z          <= r_z;
                o_ao_bottom_left  <= ao[7:6];
                o_ao_bottom_right <= ao[5:4];
                o_ao_top_left     <= ao[3:2];
                o_ao_top_right    <= ao[1:0];
                o_base_vertex     <= {r_count, 2'b00};
                o_last_face       <= ~later;
            end
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_sts.clr_done = (r_clr == AW'(DEPTH - 1));
    assign o_sts.is_mesh  = (i_mode == MODE_MESH);
    assign o_sts.rd_done  = (r_rx == 2'd2) && (r_rz == 2'd2);
    assign o_sts.emit     = emit;
    assign o_sts.out_pop  = pop;
    assign o_sts.out_last = o_last_face;

endmodule

// ===== rtl/voxel_face_cull_ao_top.sv =====
// ----------------------------------------------------------------------------
// voxel_face_cull_ao_top
// Voxel face culling with per-corner ambient occlusion over a chunk store.
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_ready   | mode, cell x/z/y, column bits
//   out     | output    | o_out_valid / i_out_ready | one face result per transfer
//
// Load and restart are done in the idle state. A mesh request first runs the column
// reads (nine reads on the single read port) and setup, then walks the directions
// in order, with the output wait for each face. After reset a clearing pass writes
// all CHUNK_SIZE*CHUNK_SIZE words with no intake. A stalled output holds the face
// walk until the transfer completes.
// ----------------------------------------------------------------------------
module voxel_face_cull_ao_top #(
    parameter int CHUNK_SIZE = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_mode,
    input  logic [4:0]                   i_cell_x,
    input  logic [4:0]                   i_cell_z,
    input  logic [4:0]                   i_cell_y,
    input  logic [31:0]                  i_column_bits,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_face_valid,
    output logic [2:0]                   o_face_dir,
    output logic [4:0]                   o_face_x,
    output logic [4:0]                   o_face_y,
    output logic [4:0]                   o_face_z,
    output logic [1:0]                   o_ao_bottom_left,
    output logic [1:0]                   o_ao_bottom_right,
    output logic [1:0]                   o_ao_top_left,
    output logic [1:0]                   o_ao_top_right,
    output logic [vfcao_pkg::BASE_W-1:0] o_base_vertex,
    output logic                         o_last_face
);
    import vfcao_pkg::*;

    t_cmd cmd;
    t_sts sts;

    vfcao_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vfcao_dp #(.CHUNK_SIZE(CHUNK_SIZE)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_mode            (i_mode),
        .i_cell_x          (i_cell_x),
        .i_cell_z          (i_cell_z),
        .i_cell_y          (i_cell_y),
        .i_column_bits     (i_column_bits),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_face_valid      (o_face_valid),
        .o_face_dir        (o_face_dir),
        .o_face_x          (o_face_x),
        .o_face_y          (o_face_y),
        .o_face_z          (o_face_z),
        .o_ao_bottom_left  (o_ao_bottom_left),
        .o_ao_bottom_right (o_ao_bottom_right),
        .o_ao_top_left     (o_ao_top_left),
        .o_ao_top_right    (o_ao_top_right),
        .o_base_vertex     (o_base_vertex),
        .o_last_face       (o_last_face)
    );

`ifndef SYNTH
    a_no_intake_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("intake open while result pending");
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_face_valid) |-> o_last_face) else $error("empty result not last");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("result dropped");
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_face_valid) |-> (o_face_dir < 3'd6)) else $error("bad face dir");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the voxel face cull / AO block: loads chunk columns, meshes
// cells, restarts the face counter, and checks every face against its own
// occupancy mirror and corner-occlusion predictor under random idling.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import vfcao_pkg::*;

    localparam int CS = 32;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic       valid;
        logic [2:0] dir;
        logic [4:0] x;
        logic [4:0] y;
        logic [4:0] z;
        logic [1:0] bl;
        logic [1:0] br;
        logic [1:0] tl;
        logic [1:0] tr;
        logic [18:0] base;
        logic       last;
    } t_face;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = MODE_LOAD;
    logic [4:0]  cx = '0;
    logic [4:0]  cz = '0;
    logic [4:0]  cy = '0;
    logic [31:0] cbits = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_face       got;

    logic [31:0] occ_mirror [CS*CS];
    logic [16:0] face_total;
    t_face       face_queue [$];
    int          errors = 0;
    int          faces_seen = 0;
    int          items_sent = 0;
    int          cycles = 0;
    int          out_gap = 0;
    bit          hold_off = 1'b0;
    bit          fast_out = 1'b0;

    // offsets as (dx, dz, dy)
    int nb_off [6][3] = '{'{0,-1,0}, '{0,1,0}, '{-1,0,0}, '{1,0,0}, '{0,0,-1}, '{0,0,1}};
    int ao_off [6][4][3][3] = '{
        '{'{'{-1,-1,0},'{0,0,0},'{-1,0,0}}, '{'{0,0,0},'{1,-1,0},'{1,0,0}},
          '{'{-1,-1,1},'{0,0,1},'{-1,0,1}}, '{'{0,0,1},'{1,-1,1},'{1,0,1}}},
        '{'{'{0,0,0},'{1,1,0},'{1,0,0}}, '{'{0,0,0},'{-1,1,0},'{-1,0,0}},
          '{'{0,0,1},'{1,1,1},'{1,0,1}}, '{'{0,0,1},'{-1,1,1},'{-1,0,1}}},
        '{'{'{0,0,0},'{-1,1,0},'{0,1,0}}, '{'{0,0,0},'{-1,-1,0},'{0,-1,0}},
          '{'{0,0,1},'{-1,1,1},'{0,1,1}}, '{'{0,0,1},'{-1,-1,1},'{0,-1,1}}},
        '{'{'{0,0,0},'{1,-1,0},'{0,-1,0}}, '{'{0,0,0},'{1,1,0},'{0,1,0}},
          '{'{0,0,1},'{1,-1,1},'{0,-1,1}}, '{'{0,0,1},'{1,1,1},'{0,1,1}}},
        '{'{'{-1,0,-1},'{0,1,-1},'{-1,1,-1}}, '{'{1,0,-1},'{0,1,-1},'{1,1,-1}},
          '{'{-1,0,-1},'{0,-1,-1},'{-1,-1,-1}}, '{'{1,0,-1},'{0,-1,-1},'{1,-1,-1}}},
        '{'{'{-1,0,1},'{0,-1,1},'{-1,-1,1}}, '{'{1,0,1},'{0,-1,1},'{1,-1,1}},
          '{'{-1,0,1},'{0,1,1},'{-1,1,1}}, '{'{1,0,1},'{0,1,1},'{1,1,1}}}
    };

    voxel_face_cull_ao_top #(.CHUNK_SIZE(CS)) i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_mode(mode), .i_cell_x(cx), .i_cell_z(cz), .i_cell_y(cy),
        .i_column_bits(cbits),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_face_valid(got.valid), .o_face_dir(got.dir),
        .o_face_x(got.x), .o_face_y(got.y), .o_face_z(got.z),
        .o_ao_bottom_left(got.bl), .o_ao_bottom_right(got.br),
        .o_ao_top_left(got.tl), .o_ao_top_right(got.tr),
        .o_base_vertex(got.base), .o_last_face(got.last)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic bit solid_at(int x, int z, int y);
        if (x < 0 || z < 0 || y < 0 || x >= CS || z >= CS || y >= CS)
            return 1'b0;
        return occ_mirror[x*CS + z][y];
    endfunction

    function automatic logic [1:0] corner_ao(bit s1, bit s2, bit c);
        if (s1 && s2)
            return 2'd0;
        return 2'(3 - (int'(s1) + int'(s2) + int'(c)));
    endfunction

    task automatic predict_faces(int x, int z, int y);
        t_face f;
        logic [1:0] lv [4];
        int n;
        n = 0;
        if (solid_at(x, z, y)) begin
            for (int d = 0; d < 6; d++) begin
                if (solid_at(x + nb_off[d][0], z + nb_off[d][1], y + nb_off[d][2]))
                    continue;
                for (int k = 0; k < 4; k++) begin
                    lv[k] = corner_ao(
                        solid_at(x+ao_off[d][k][0][0], z+ao_off[d][k][0][1], y+ao_off[d][k][0][2]),
                        solid_at(x+ao_off[d][k][1][0], z+ao_off[d][k][1][1], y+ao_off[d][k][1][2]),
                        solid_at(x+ao_off[d][k][2][0], z+ao_off[d][k][2][1], y+ao_off[d][k][2][2]));
                end
                f = '{1'b1, 3'(d), 5'(x), 5'(y), 5'(z), lv[0], lv[1], lv[2], lv[3],
                      19'({face_total, 2'b00}), 1'b0};
                face_total = face_total + 17'd1;
                face_queue.push_back(f);
                n++;
            end
        end
        if (n == 0) begin
            f = '0;
            f.last = 1'b1;
            face_queue.push_back(f);
        end else begin
            face_queue[$].last = 1'b1;
        end
    endtask

    task automatic send_item(logic [1:0] m, logic [4:0] x, logic [4:0] z, logic [4:0] y,
                             logic [31:0] bits, bit gaps = 1'b1);
        if (gaps && $urandom_range(0, 2) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
                @(negedge clk);
        end
        mode <= m; cx <= x; cz <= z; cy <= y; cbits <= bits;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        case (m)
            MODE_LOAD:    occ_mirror[x*CS + z] = bits;
            MODE_MESH:    predict_faces(x, z, y);
            MODE_RESTART: face_total = '0;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic report_mismatch(string what, int exp_v, int got_v);
        errors++;
        $display("mismatch %s: expected %0d got %0d (face %0d)", what, exp_v, got_v, faces_seen);
    endtask

    always @(negedge clk) begin
        if (hold_off) begin
            out_ready <= 1'b0;
        end else if (fast_out) begin
            out_ready <= 1'b1;
        end else if (out_gap > 0) begin
            out_gap--;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 40) == 0) begin
            out_gap = $urandom_range(10, 40);
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk) begin
        t_face e;
        if (rst_n && out_valid && out_ready) begin
            faces_seen++;
            if (face_queue.size() == 0) begin
                errors++;
                $display("unexpected transfer on output");
            end else begin
                e = face_queue.pop_front();
                if (got.valid !== e.valid) report_mismatch("face_valid", e.valid, got.valid);
                if (got.dir !== e.dir) report_mismatch("face_dir", e.dir, got.dir);
                if (got.x !== e.x) report_mismatch("face_x", e.x, got.x);
                if (got.y !== e.y) report_mismatch("face_y", e.y, got.y);
                if (got.z !== e.z) report_mismatch("face_z", e.z, got.z);
                if (got.bl !== e.bl) report_mismatch("ao_bottom_left", e.bl, got.bl);
                if (got.br !== e.br) report_mismatch("ao_bottom_right", e.br, got.br);
                if (got.tl !== e.tl) report_mismatch("ao_top_left", e.tl, got.tl);
                if (got.tr !== e.tr) report_mismatch("ao_top_right", e.tr, got.tr);
                if (got.base !== e.base) report_mismatch("base_vertex", e.base, got.base);
                if (got.last !== e.last) report_mismatch("last_face", e.last, got.last);
            end
        end
    end

    task automatic test_directed();
        send_item(MODE_MESH, 5'd0, 5'd0, 5'd0, '0);
        send_item(MODE_LOAD, 5'd0, 5'd0, 5'd0, 32'hFFFF_FFFF);
        send_item(MODE_MESH, 5'd0, 5'd0, 5'd0, '0);
        send_item(MODE_MESH, 5'd0, 5'd0, 5'd31, '0);
        send_item(MODE_LOAD, 5'd1, 5'd0, 5'd0, 32'hAAAA_5555);
        send_item(MODE_LOAD, 5'd0, 5'd1, 5'd0, 32'h5555_AAAA);
        send_item(MODE_MESH, 5'd0, 5'd0, 5'd16, '0);
        send_item(2'd3, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF);
        send_item(MODE_RESTART, 5'd0, 5'd0, 5'd0, '0);
        // enclosed cell: all six neighbors solid
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                send_item(MODE_LOAD, 5'(14 + i), 5'(14 + j), 5'd0, 32'h0000_0070);
        send_item(MODE_MESH, 5'd15, 5'd15, 5'd5, '0);
        send_item(MODE_MESH, 5'd14, 5'd14, 5'd4, '0);
        send_item(MODE_LOAD, 5'd31, 5'd31, 5'd0, 32'h8000_0001);
        send_item(MODE_MESH, 5'd31, 5'd31, 5'd31, '0);
        send_item(MODE_MESH, 5'd31, 5'd31, 5'd0, '0);
        send_item(MODE_MESH, 5'd31, 5'd31, 5'd15, '0);
    endtask

    task automatic test_random();
        int bx, bz;
        for (int n = 0; n < 80; n++) begin
            bx = $urandom_range(0, 3) * 8 + $urandom_range(0, 4);
            bz = $urandom_range(0, 3) * 8 + $urandom_range(0, 4);
            case ($urandom_range(0, 9))
                0, 1, 2: send_item(MODE_LOAD, 5'(bx), 5'(bz), 5'd0, $urandom());
                3, 4, 5, 6, 7: send_item(MODE_MESH, 5'(bx), 5'(bz), 5'($urandom()), '0);
                8: send_item(MODE_RESTART, 5'($urandom()), 5'($urandom()), 5'($urandom()),
                             $urandom());
                default: send_item(2'd3, 5'($urandom()), 5'($urandom()), 5'($urandom()),
                                   $urandom());
            endcase
        end
    endtask

    task automatic test_stall_pressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 12; n++)
                send_item(MODE_MESH, 5'(n), 5'd0, 5'($urandom_range(0, 31)), '0, 1'b0);
        join
        fast_out = 1'b1;
        for (int n = 0; n < 10; n++)
            send_item(MODE_MESH, 5'd1, 5'(n), 5'($urandom_range(0, 31)), '0, 1'b0);
        fast_out = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < CS*CS; i++)
            occ_mirror[i] = '0;
        face_total = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random();
        test_stall_pressure();
        in_valid <= 1'b0;
        while (face_queue.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("sent %0d items (loads, meshes, restarts, unused mode), checked %0d results",
                 items_sent, faces_seen);
        $display("face counter restart, chunk edges, enclosed cells and long output stall covered");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
